// ----- rtl/blhp_pkg.sv -----
`default_nettype none

package blhp_pkg;

  // sequencer steps around the shared adder
  typedef enum logic [11:0] {
    S_IN   = 12'b0000_0000_0001,
    S_DIV  = 12'b0000_0000_0010,
    S_FIX  = 12'b0000_0000_0100,
    S_XADD = 12'b0000_0000_1000,
    S_VFIN = 12'b0000_0001_0000,
    S_EB2  = 12'b0000_0010_0000,
    S_CHK  = 12'b0000_0100_0000,
    S_SUM  = 12'b0000_1000_0000,
    S_EMIT = 12'b0001_0000_0000,
    S_REM  = 12'b0010_0000_0000,
    S_REM2 = 12'b0100_0000_0000,
    S_LAST = 12'b1000_0000_0000
  } seq_state_t;

  // where the parser stands inside the lace header
  typedef enum logic [5:0] {
    PH_IDLE          = 6'b00_0001,
    PH_XIPH          = 6'b00_0010,
    PH_EB_FIRST      = 6'b00_0100,
    PH_EB_DELTA      = 6'b00_1000,
    PH_EB_FIRST_CONT = 6'b01_0000,
    PH_EB_DELTA_CONT = 6'b10_0000
  } lace_phase_t;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_XIPH  = 2'd1;
  localparam logic [1:0] MODE_FIXED = 2'd2;
  localparam logic [1:0] MODE_EBML  = 2'd3;

  localparam int         VINT_BITS = 56;
  localparam logic [7:0] XIPH_RUN  = 8'hFF;

  // signed vint bias, 2^(7n-1)-1 for an n-byte vint
  function automatic logic [55:0] ebml_bias(input logic [3:0] n);
    case (n)
      4'd1:    ebml_bias = 56'h3F;
      4'd2:    ebml_bias = 56'h1FFF;
      4'd3:    ebml_bias = 56'hF_FFFF;
      4'd4:    ebml_bias = 56'h7FF_FFFF;
      4'd5:    ebml_bias = 56'h3_FFFF_FFFF;
      4'd6:    ebml_bias = 56'h1FF_FFFF_FFFF;
      4'd7:    ebml_bias = 56'hFFFF_FFFF_FFFF;
      4'd8:    ebml_bias = 56'h7F_FFFF_FFFF_FFFF;
      default: ebml_bias = 56'h0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- rtl/block_lace_header_parser.sv -----
// lace header and idle bytes that complete no frame stay in S_IN, a xiph 255 byte passes S_XADD
// a byte closing a frame size runs S_XADD or S_VFIN (plus S_EB2 for an ebml delta), S_CHK, S_SUM,
// S_EMIT, then S_REM, S_REM2 and S_LAST for the last laced frame, which alone run for no lacing
// or a zero count; fixed lacing runs one restoring division step per cycle, 32 steps, then S_FIX
// every step uses one shared adder, so one beat is worked on at a time; stalls hold emit states
// synchronous reset idles the parser and drops any pending output beat
`default_nettype none

module block_lace_header_parser import blhp_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        block_start,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] data_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      frame_size,
  output logic [8:0]       repeat_count,
  output logic             last,
  output logic [31:0]      header_length,
  output logic             size_error
);

  localparam int AW = ((SIZE_BITS > VINT_BITS) ? SIZE_BITS : VINT_BITS) + 3;
  localparam int XW = SIZE_BITS + 1;
  localparam logic [AW-1:0] ONE     = AW'(1);
  localparam logic [AW-1:0] LIM1    = ONE << SIZE_BITS;
  localparam logic [AW-1:0] LIMIT   = LIM1 - ONE;
  localparam logic [AW-1:0] SUM_CAP = ONE << 32;

  seq_state_t    state;
  lace_phase_t   phase;

  logic [31:0]          payload_total;
  logic [31:0]          header_count;
  logic [32:0]          size_sum;
  logic [XW-1:0]        xiph_running;
  logic [SIZE_BITS-1:0] prev_size;
  logic [SIZE_BITS-1:0] size_val;
  logic [VINT_BITS-1:0] vint_value;
  logic [3:0]           vint_length;
  logic [2:0]           vint_left;
  logic                 vfirst;
  logic [7:0]           frames_left;
  logic [7:0]           byte_r;
  logic                 err;
  logic [AW-1:0]        wv;
  logic [31:0]          div_q;
  logic [8:0]           div_r;
  logic [8:0]           div_frames;
  logic [4:0]           div_cnt;

  logic [AW-1:0]        add_a;
  logic [AW-1:0]        add_b;
  logic                 add_cin;
  logic [AW-1:0]        add_res;
  logic                 take;
  logic [AW-1:0]        xsum;
  logic                 chk_bad;
  logic [SIZE_BITS-1:0] chk_s;
  logic                 fix_bad;
  logic [3:0]           lead_n;
  logic [7:0]           lead_mask;
  logic                 out_free;
  logic                 out_load;

  assign in_stall = (state != S_IN);
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && ((state == S_FIX) || (state == S_EMIT) || (state == S_LAST));

  // shared adder, operands picked by the sequencer
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (state)
      S_DIV: begin
        add_a   = AW'({div_r, div_q[31]});
        add_b   = ~AW'(div_frames);
        add_cin = 1'b1;
      end
      S_XADD: begin
        add_a = AW'(xiph_running);
        add_b = AW'(byte_r);
      end
      S_VFIN: begin
        add_a = AW'(prev_size);
        add_b = AW'(vint_value);
      end
      S_EB2: begin
        add_a   = wv;
        add_b   = ~AW'(ebml_bias(vint_length));
        add_cin = 1'b1;
      end
      S_SUM: begin
        add_a = AW'(size_sum);
        add_b = AW'(size_val);
      end
      S_REM: begin
        add_a   = AW'(payload_total);
        add_b   = ~AW'(header_count);
        add_cin = 1'b1;
      end
      S_REM2: begin
        add_a   = wv;
        add_b   = ~AW'(size_sum);
        add_cin = 1'b1;
      end
      default: ;
    endcase
    add_res = add_a + add_b + AW'(add_cin);
  end

  assign take    = !add_res[AW-1];
  assign xsum    = (add_res > LIM1) ? LIM1 : add_res;
  // negative values wrap above the limit too
  assign chk_bad = (wv > LIMIT);
  assign chk_s   = chk_bad ? '0 : SIZE_BITS'(wv);
  assign fix_bad = (AW'(div_q) > LIMIT);

  // vint length from the leading one of the first byte
  always_comb begin
    lead_n = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (data_byte[i]) lead_n = 4'(8 - i);
    end
    lead_mask = 8'hFF >> lead_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      phase     <= PH_IDLE;
    end else begin
      case (state)
        S_IN: begin
          if (in_valid) begin
            if (block_start) begin
              payload_total <= data_size;
              size_sum      <= '0;
              prev_size     <= '0;
              xiph_running  <= '0;
              vint_value    <= '0;
              err           <= 1'b0;
              header_count  <= (mode == MODE_NONE) ? 32'd0 : 32'd1;
              phase         <= PH_IDLE;
              case (mode)
                MODE_NONE: state <= S_REM;
                MODE_FIXED: begin
                  div_frames <= {1'b0, data_byte} + 9'd1;
                  div_r      <= '0;
                  div_cnt    <= '0;
                  if (data_size == 32'd0) begin
                    err   <= 1'b1;
                    div_q <= '0;
                    state <= S_FIX;
                  end else begin
                    div_q <= data_size - 32'd1;
                    state <= S_DIV;
                  end
                end
                MODE_XIPH, MODE_EBML: begin
                  if (data_byte == 8'd0) begin
                    state <= S_REM;
                  end else begin
                    frames_left <= data_byte;
                    phase       <= (mode == MODE_XIPH) ? PH_XIPH : PH_EB_FIRST;
                  end
                end
                default: ;
              endcase
            end else if (phase != PH_IDLE) begin
              if (header_count != 32'hFFFF_FFFF) header_count <= header_count + 32'd1;
              case (phase)
                PH_XIPH: begin
                  byte_r <= data_byte;
                  state  <= S_XADD;
                end
                PH_EB_FIRST, PH_EB_DELTA: begin
                  vfirst <= (phase == PH_EB_FIRST);
                  if (data_byte == 8'd0) begin
                    // zero lead byte reads as a one-byte vint of zero
                    err         <= 1'b1;
                    vint_length <= 4'd1;
                    vint_value  <= '0;
                    state       <= S_VFIN;
                  end else begin
                    vint_length <= lead_n;
                    vint_value  <= VINT_BITS'(data_byte & lead_mask);
                    if (lead_n == 4'd1) begin
                      state <= S_VFIN;
                    end else begin
                      vint_left <= 3'(lead_n - 4'd1);
                      phase     <= (phase == PH_EB_FIRST) ? PH_EB_FIRST_CONT
                                                          : PH_EB_DELTA_CONT;
                    end
                  end
                end
                PH_EB_FIRST_CONT, PH_EB_DELTA_CONT: begin
                  vfirst     <= (phase == PH_EB_FIRST_CONT);
                  vint_value <= {vint_value[VINT_BITS-9:0], data_byte};
                  vint_left  <= vint_left - 3'd1;
                  if (vint_left <= 3'd1) state <= S_VFIN;
                end
                default: phase <= PH_IDLE;
              endcase
            end
          end
        end
        S_DIV: begin
          div_q   <= {div_q[30:0], take};
          div_r   <= take ? add_res[8:0] : {div_r[7:0], div_q[31]};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) state <= S_FIX;
        end
        S_FIX: begin
          if (out_free) begin
            frame_size    <= fix_bad ? 32'd0 : div_q;
            repeat_count  <= div_frames;
            last          <= 1'b1;
            header_length <= header_count;
            size_error    <= err || fix_bad;
            err           <= err || fix_bad;
            state         <= S_IN;
          end
        end
        S_XADD: begin
          if (byte_r == XIPH_RUN) begin
            xiph_running <= XW'(xsum);
            state        <= S_IN;
          end else begin
            xiph_running <= '0;
            wv           <= xsum;
            state        <= S_CHK;
          end
        end
        S_VFIN: begin
          // delta sizes first add the previous size, then drop the bias
          wv    <= vfirst ? AW'(vint_value) : add_res;
          state <= vfirst ? S_CHK : S_EB2;
        end
        S_EB2: begin
          wv    <= add_res;
          state <= S_CHK;
        end
        S_CHK: begin
          size_val  <= chk_s;
          prev_size <= chk_s;
          if (chk_bad) err <= 1'b1;
          if (frames_left != 8'd0) frames_left <= frames_left - 8'd1;
          state <= S_SUM;
        end
        S_SUM: begin
          // running sum pins at 2^32, reaching it counts as overflow
          if (add_res >= SUM_CAP) begin
            size_sum <= 33'h1_0000_0000;
            err      <= 1'b1;
          end else begin
            size_sum <= 33'(add_res);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            frame_size    <= 32'(size_val);
            repeat_count  <= 9'd1;
            last          <= 1'b0;
            header_length <= 32'd0;
            size_error    <= err;
            if (frames_left == 8'd0) begin
              state <= S_REM;
            end else begin
              state <= S_IN;
              phase <= (phase == PH_XIPH) ? PH_XIPH : PH_EB_DELTA;
            end
          end
        end
        S_REM: begin
          wv    <= add_res;
          state <= S_REM2;
        end
        S_REM2: begin
          wv    <= add_res;
          state <= S_LAST;
        end
        S_LAST: begin
          // last frame gets whatever the header and earlier frames left over
          if (out_free) begin
            frame_size    <= 32'(chk_s);
            repeat_count  <= 9'd1;
            last          <= 1'b1;
            header_length <= header_count;
            size_error    <= err || chk_bad;
            err           <= err || chk_bad;
            phase         <= PH_IDLE;
            state         <= S_IN;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import blhp_pkg::*;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        block_start;
    logic [1:0]  mode;
    logic [31:0] data_size;
  } lace_beat_t;

  typedef struct packed {
    logic [31:0] frame_size;
    logic [8:0]  repeat_count;
    logic        last;
    logic [31:0] header_length;
    logic        size_error;
  } frame_info_t;

  localparam longint SIZE_CEIL = 64'hFFFF_FFFF;

  // lace header decoder mirror plus the frames it still owes
  class frame_size_board;
    lace_phase_t   hdr_phase;
    longint        block_bytes;
    int            sizes_left;
    longint        vint_acc;
    int            vint_todo;
    int            vint_len;
    longint        prev_size;
    longint        sizes_total;
    longint        xiph_acc;
    longint        hdr_bytes;
    bit            bad_block;
    frame_info_t   expected_frames[$];
    int            mismatches;

    function new();
      mismatches = 0;
      clear_block();
    endfunction

    function void clear_block();
      hdr_phase   = PH_IDLE;
      block_bytes = 0;
      sizes_left  = 0;
      vint_acc    = 0;
      vint_todo   = 0;
      vint_len    = 0;
      prev_size   = 0;
      sizes_total = 0;
      xiph_acc    = 0;
      hdr_bytes   = 0;
      bad_block   = 1'b0;
    endfunction

    function longint size_or_flag(longint v);
      if (v < 0 || v > SIZE_CEIL) begin
        bad_block = 1'b1;
        return 0;
      end
      return v;
    endfunction

    function void push_frame(longint size, longint reps, bit is_last, longint hdr);
      frame_info_t f;
      f.frame_size    = size[31:0];
      f.repeat_count  = reps[8:0];
      f.last          = is_last;
      f.header_length = hdr[31:0];
      f.size_error    = bad_block;
      expected_frames.insert(expected_frames.size(), f);
    endfunction

    function longint add_size(longint v);
      longint s;
      s = size_or_flag(v);
      sizes_total += s;
      // running sum pins at 2^32
      if (sizes_total > SIZE_CEIL) begin
        sizes_total = SIZE_CEIL + 1;
        bad_block   = 1'b1;
      end
      push_frame(s, 1, 1'b0, 0);
      return s;
    endfunction

    function void close_block();
      push_frame(size_or_flag(block_bytes - hdr_bytes - sizes_total), 1, 1'b1, hdr_bytes);
      hdr_phase = PH_IDLE;
    endfunction

    function void vint_done(bit first_size);
      longint v;
      longint bias;
      if (first_size) begin
        v = vint_acc;
      end else begin
        bias = (longint'(1) << (7 * vint_len - 1)) - 1;
        v = prev_size + (vint_acc - bias);
      end
      prev_size = add_size(v);
      vint_acc  = 0;
      vint_todo = 0;
      if (sizes_left > 0) sizes_left--;
      if (sizes_left == 0) close_block();
      else hdr_phase = PH_EB_DELTA;
    endfunction

    function void take_byte(lace_beat_t b);
      longint frames;
      longint q;
      logic [7:0] mask;
      int n;
      bit first_size;
      if (b.block_start) begin
        clear_block();
        block_bytes = longint'(b.data_size);
        if (b.mode == MODE_NONE) begin
          close_block();
          return;
        end
        hdr_bytes = 1;
        if (b.mode == MODE_FIXED) begin
          frames = longint'(b.data_byte) + 1;
          q = 0;
          if (b.data_size == 32'd0) bad_block = 1'b1;
          else q = size_or_flag((block_bytes - 1) / frames);
          push_frame(q, frames, 1'b1, hdr_bytes);
          return;
        end
        if (b.data_byte == 8'd0) begin
          close_block();
          return;
        end
        sizes_left = b.data_byte;
        hdr_phase  = (b.mode == MODE_XIPH) ? PH_XIPH : PH_EB_FIRST;
        return;
      end
      if (hdr_phase == PH_IDLE) return;
      if (hdr_bytes < SIZE_CEIL) hdr_bytes++;
      case (hdr_phase)
        PH_XIPH: begin
          xiph_acc += b.data_byte;
          if (xiph_acc > SIZE_CEIL + 1) xiph_acc = SIZE_CEIL + 1;
          if (b.data_byte == XIPH_RUN) return;
          void'(add_size(xiph_acc));
          xiph_acc = 0;
          if (sizes_left > 0) sizes_left--;
          if (sizes_left == 0) close_block();
        end
        PH_EB_FIRST, PH_EB_DELTA: begin
          first_size = (hdr_phase == PH_EB_FIRST);
          // a zero lead byte reads as a one-byte vint of zero
          if (b.data_byte == 8'd0) begin
            bad_block = 1'b1;
            vint_len  = 1;
            vint_acc  = 0;
            vint_done(first_size);
            return;
          end
          n = 1;
          mask = 8'h80;
          while ((b.data_byte & mask) == 8'd0) begin
            mask = mask >> 1;
            n++;
          end
          vint_len = n;
          vint_acc = longint'(b.data_byte & (mask - 8'd1));
          if (n == 1) begin
            vint_done(first_size);
          end else begin
            vint_todo = n - 1;
            hdr_phase = first_size ? PH_EB_FIRST_CONT : PH_EB_DELTA_CONT;
          end
        end
        PH_EB_FIRST_CONT, PH_EB_DELTA_CONT: begin
          first_size = (hdr_phase == PH_EB_FIRST_CONT);
          vint_acc = ((vint_acc << 8) | longint'(b.data_byte)) & 64'h00FF_FFFF_FFFF_FFFF;
          if (vint_todo > 0) vint_todo--;
          if (vint_todo == 0) vint_done(first_size);
        end
        default: hdr_phase = PH_IDLE;
      endcase
    endfunction

    function void check_frame(frame_info_t got);
      frame_info_t want;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame: size %0d rep %0d last %0b hdr %0d err %0b",
                   got.frame_size, got.repeat_count, got.last, got.header_length,
                   got.size_error);
        return;
      end
      want = expected_frames.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("frame mismatch: want size %0d rep %0d last %0b hdr %0d err %0b",
                   want.frame_size, want.repeat_count, want.last, want.header_length,
                   want.size_error);
          $display("                got  size %0d rep %0d last %0b hdr %0d err %0b",
                   got.frame_size, got.repeat_count, got.last, got.header_length,
                   got.size_error);
        end
      end
    endfunction

    function void count_leftover();
      if (expected_frames.size() != 0) begin
        $display("%0d expected frames never came out", expected_frames.size());
        mismatches += expected_frames.size();
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        block_start = 1'b0;
  logic [1:0]  mode = MODE_NONE;
  logic [31:0] data_size = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] frame_size;
  logic [8:0]  repeat_count;
  logic        last;
  logic [31:0] header_length;
  logic        size_error;

  frame_size_board board;
  int          burst_left = 0;
  int          useful_beats = 0;
  logic [9:0]  stall_tick = 10'd0;

  block_lace_header_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .block_start   (block_start),
    .mode          (mode),
    .data_size     (data_size),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_size    (frame_size),
    .repeat_count  (repeat_count),
    .last          (last),
    .header_length (header_length),
    .size_error    (size_error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: quiet, light, heavy and periodic stall stretches
  always @(posedge clk) begin
    stall_tick <= stall_tick + 10'd1;
    case (stall_tick[8:7])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 9) < 3);
      2'd2:    out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= (stall_tick[2:0] < 3'd5);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_frame({frame_size, repeat_count, last, header_length, size_error});
  end

  task automatic send_beat(input logic [7:0] byte_v, input logic start_v,
                           input logic [1:0] mode_v, input logic [31:0] size_v,
                           input bit ignored = 1'b0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    data_byte   <= byte_v;
    block_start <= start_v;
    mode        <= mode_v;
    data_size   <= size_v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte({byte_v, start_v, mode_v, size_v});
    if (!ignored) useful_beats++;
  endtask

  // header byte; mode and size lines carry noise the block must not read
  task automatic send_lace_byte(input logic [7:0] byte_v);
    send_beat(byte_v, 1'b0, 2'($urandom), $urandom);
  endtask

  task automatic send_vint(input int n, input longint value);
    logic [7:0] b;
    for (int i = n - 1; i >= 0; i--) begin
      b = 8'(value >> (8 * i));
      if (i == n - 1) b = b | (8'h80 >> (n - 1));
      send_lace_byte(b);
    end
  endtask

  task automatic send_trailer();
    repeat ($urandom_range(0, 3)) send_beat(8'($urandom), 1'b0, 2'($urandom), $urandom, 1'b1);
  endtask

  task automatic random_block();
    logic [1:0]  md;
    logic [31:0] sz;
    int          count;
    int          n;
    bit          broken;
    longint      maxv;
    longint      value;
    md = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       sz = $urandom;
      1:       sz = $urandom_range(1, 40);
      default: sz = $urandom_range(1, 3000);
    endcase
    if (sz == 32'd0) sz = 32'd1;
    count = ($urandom_range(0, 59) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
    broken = ($urandom_range(0, 7) == 0);
    send_beat(8'(count), 1'b1, md, sz);
    if (md == MODE_XIPH) begin
      for (int f = 0; f < count; f++) begin
        // cut short: the next block start drops this one
        if (broken && $urandom_range(0, 2) == 0) return;
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 5)) send_lace_byte(XIPH_RUN);
        send_lace_byte(8'($urandom_range(0, 254)));
      end
    end else if (md == MODE_EBML) begin
      for (int f = 0; f < count; f++) begin
        if (broken && $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 1) == 0) send_lace_byte(8'h40 | 8'($urandom_range(0, 63)));
          return;
        end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 8) : $urandom_range(1, 2);
        maxv = (longint'(1) << (7 * n)) - 1;
        if ($urandom_range(0, 24) == 0) begin
          send_lace_byte(8'h00);
        end else if (f == 0 || $urandom_range(0, 3) == 0) begin
          value = longint'({$urandom, $urandom}) & maxv;
          send_vint(n, value);
        end else begin
          // delta close to zero around the bias
          value = (longint'(1) << (7 * n - 1)) - 1 + longint'($urandom_range(0, 400)) - 200;
          if (value < 0) value = 0;
          if (value > maxv) value = maxv;
          send_vint(n, value);
        end
      end
    end
    send_trailer();
  endtask

  initial begin
    int target;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // idle bytes before any block start
    send_beat(8'hA5, 1'b0, MODE_EBML, 32'h0000_1234, 1'b1);
    send_beat(8'h5A, 1'b0, MODE_XIPH, 32'hFFFF_0000, 1'b1);
    send_beat(8'h00, 1'b1, MODE_NONE, 32'd1);
    send_beat(8'hFF, 1'b1, MODE_NONE, 32'hFFFF_FFFF);
    send_beat(8'h00, 1'b1, MODE_FIXED, 32'd1);
    send_beat(8'hFF, 1'b1, MODE_FIXED, 32'hFFFF_FFFF);
    // xiph header dropped mid-run by the following block start
    send_beat(8'h02, 1'b1, MODE_XIPH, 32'd9);
    send_lace_byte(XIPH_RUN);
    send_beat(8'h00, 1'b1, MODE_XIPH, 32'd100);
    send_beat(8'h01, 1'b1, MODE_XIPH, 32'd600);
    send_lace_byte(XIPH_RUN);
    send_lace_byte(XIPH_RUN);
    send_lace_byte(8'h0A);
    send_beat(8'h00, 1'b1, MODE_EBML, 32'd7);
    // negative delta, then a payload byte that must be ignored
    send_beat(8'h02, 1'b1, MODE_EBML, 32'd50);
    send_lace_byte(8'h81);
    send_lace_byte(8'h80);
    send_beat(8'h77, 1'b0, MODE_FIXED, 32'd3, 1'b1);
    send_beat(8'h01, 1'b1, MODE_EBML, 32'd20);
    send_lace_byte(8'h00);
    // max first size, sum overflow, oversize delta, then a delta from zero
    send_beat(8'h04, 1'b1, MODE_EBML, 32'd10);
    send_vint(5, 64'hFFFF_FFFF);
    send_lace_byte(8'hBF);
    send_lace_byte(8'hFF);
    send_lace_byte(8'hC0);

    target = useful_beats + 450;
    while (useful_beats < target) random_block();
    in_valid <= 1'b0;

    while (board.expected_frames.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    board.count_leftover();
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- block_lace_header_parser.f -----
rtl/blhp_pkg.sv
rtl/block_lace_header_parser.sv
bench/testbench.sv
